### rtl/xor_distance_kbucket_table_defines.svh
// ---------------------------------------------------------------------------
// XOR-distance k-bucket table assertion macros
// Shared concurrent assertion forms, clocked on clk_i, muted in reset.
// ---------------------------------------------------------------------------
`ifndef XOR_DISTANCE_KBUCKET_TABLE_DEFINES_SVH
`define XOR_DISTANCE_KBUCKET_TABLE_DEFINES_SVH

// same-cycle implication
`define XDKB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define XDKB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/xdkb_pkg.sv
// ---------------------------------------------------------------------------
// XOR-distance k-bucket table package
// Field widths, default sizes, action, status and register codes.
// ---------------------------------------------------------------------------
package xdkb_pkg;

  localparam int BUCKET_SLOTS_DEF = 8;
  localparam int KEY_BITS_DEF     = 64;

  localparam int KEY_W    = 64;
  localparam int REF_W    = 32;
  localparam int RT_W     = 16;
  localparam int STAT_W   = 4;
  localparam int BKT_W    = 6;
  localparam int SIZE_W   = 10;
  localparam int CAP_W    = 4;
  localparam int ACT_W    = 2;
  localparam int IN_W     = 176;
  localparam int OUT_W    = 136;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 64;
  localparam logic [CAP_W-1:0] CAP_RST = 4'd8;

  localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_NEAREST = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHECK   = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED = 4'd0;
  localparam logic [STAT_W-1:0] ST_EVICTED  = 4'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 4'd2;
  localparam logic [STAT_W-1:0] ST_SELF     = 4'd3;
  localparam logic [STAT_W-1:0] ST_DUP      = 4'd4;
  localparam logic [STAT_W-1:0] ST_FOUND    = 4'd5;
  localparam logic [STAT_W-1:0] ST_ABSENT   = 4'd6;
  localparam logic [STAT_W-1:0] ST_NEIGHBOR = 4'd7;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 4'd8;

  localparam logic REG_LOCAL_KEY = 1'b0;
  localparam logic REG_CAPACITY  = 1'b1;

endpackage

### rtl/xor_distance_kbucket_table.sv
// Sequence: an insert of the own key goes straight to its result beat; other inserts run
// a leading-zero walk, then a scan with one slot read per cycle; check and nearest skip
// the walk, and nearest gives one beat per neighbor. DEPTH = KEY_BITS * BUCKET_SLOTS (512).
// One item at a time (slot memory with one write and one read port); not ready meanwhile.
// Reset: asynchronous, active low; afterwards a clearing pass over the slot memory marks every
// slot empty before the first item is taken (register writes are taken during it).
// ---------------------------------------------------------------------------
// XOR-distance k-bucket routing table
// Peers stored in a slot memory, scanned by a small sequencer for insert,
// nearest-neighbor and membership requests.
// ---------------------------------------------------------------------------
module xor_distance_kbucket_table #(
  parameter int BUCKET_SLOTS = xdkb_pkg::BUCKET_SLOTS_DEF,
  parameter int KEY_BITS     = xdkb_pkg::KEY_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // peer_key[63:0], peer_ref[95:64], round_trip[111:96], lookup_target[175:112]
  input  logic [xdkb_pkg::IN_W-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  logic [xdkb_pkg::ACT_W-1:0] s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // status[3:0], out_key[67:4], out_ref[99:68], out_round_trip[115:100],
  // bucket_index[121:116], table_size[131:122], zero[135:132]
  output logic [xdkb_pkg::OUT_W-1:0] m_axis_tdata_o,
  output logic                       m_axis_tlast_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [xdkb_pkg::APB_AW-1:0] paddr,
  input  logic [xdkb_pkg::APB_DW-1:0] pwdata,
  output logic [xdkb_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import xdkb_pkg::*;

  localparam int DEPTH = KEY_BITS * BUCKET_SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int BW    = $clog2(KEY_BITS);
  localparam int NW    = $clog2(BUCKET_SLOTS + 1);
  localparam int IW    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int EW    = 1 + KEY_BITS + REF_W + RT_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LZC, S_SCAN, S_DECIDE, S_EMIT
  } state_e;

  state_e                    state_q;
  logic [KEY_W-1:0]          lnk_q;
  logic [CAP_W-1:0]          cap_q;
  logic [CW-1:0]             ptr_q;
  logic [CW-1:0]             count_q;
  logic                      tvld_q;
  logic [AW-1:0]             tag_q;
  logic [EW-1:0]             rdata_q;
  logic [EW-1:0]             mem_q [DEPTH];

  logic [ACT_W-1:0]          op_q;
  logic [KEY_BITS-1:0]       key_q, tgt_q, dist_q;
  logic [REF_W-1:0]          act_q;
  logic [RT_W-1:0]           rt_q;
  logic [BW-1:0]             bkt_q;
  logic [CW-1:0]             base_q;

  logic                      found_q, free_vld_q, max_vld_q;
  logic [AW-1:0]             free_q, max_slot_q;
  logic [NW-1:0]             n_q;
  logic [KEY_BITS-1:0]       max_key_q;
  logic [REF_W-1:0]          max_act_q;
  logic [RT_W-1:0]           max_lat_q;

  logic [BUCKET_SLOTS-1:0]   nk_vld_q, nk_vld_d;
  logic [KEY_BITS-1:0]       nk_key_q [BUCKET_SLOTS];
  logic [KEY_BITS-1:0]       nk_key_d [BUCKET_SLOTS];
  logic [REF_W-1:0]          nk_act_q [BUCKET_SLOTS];
  logic [REF_W-1:0]          nk_act_d [BUCKET_SLOTS];
  logic [RT_W-1:0]           nk_lat_q [BUCKET_SLOTS];
  logic [RT_W-1:0]           nk_lat_d [BUCKET_SLOTS];
  logic [IW-1:0]             eidx_q;

  logic [STAT_W-1:0]         pend_st_q;
  logic [KEY_BITS-1:0]       pend_key_q;
  logic [REF_W-1:0]          pend_ref_q;
  logic [RT_W-1:0]           pend_rt_q;
  logic [BW-1:0]             pend_bkt_q;

  logic                      m_tvalid_q, m_tlast_q;
  logic [OUT_W-1:0]          m_tdata_q;

  function automatic logic triple_gt(logic [RT_W-1:0] l1, logic [KEY_BITS-1:0] k1,
                                     logic [REF_W-1:0] a1, logic [RT_W-1:0] l2,
                                     logic [KEY_BITS-1:0] k2, logic [REF_W-1:0] a2);
    if (l1 != l2) return l1 > l2;
    if (k1 != k2) return k1 > k2;
    return a1 > a2;
  endfunction

  // slot entry fields
  logic                e_vld;
  logic [KEY_BITS-1:0] e_key, d_new;
  logic [REF_W-1:0]    e_act;
  logic [RT_W-1:0]     e_lat;
  assign e_vld = rdata_q[EW-1];
  assign e_key = rdata_q[EW-2 -: KEY_BITS];
  assign e_act = rdata_q[RT_W +: REF_W];
  assign e_lat = rdata_q[RT_W-1:0];
  assign d_new = tgt_q ^ e_key;

  logic [NW-1:0] cap_eff;
  always_comb begin
    if (cap_q == '0) cap_eff = NW'(1);
    else if (int'(cap_q) > BUCKET_SLOTS) cap_eff = NW'(BUCKET_SLOTS);
    else cap_eff = NW'(cap_q);
  end

  logic accept, cfg_wr, self_hit, hit, in_bkt, e_gt_max, new_gt_max;
  logic scan_done, out_free, ins_free, ins_drop, ins_evict, mem_we, nlast;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic [BUCKET_SLOTS-1:0] vnext;

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign self_hit  = s_axis_tdata_i[KEY_BITS-1:0] == lnk_q[KEY_BITS-1:0];
  assign hit       = tvld_q && e_vld && (e_key == key_q) && (e_act == act_q);
  assign in_bkt    = tvld_q && (op_q == ACT_INSERT) && (CW'(tag_q) >= base_q)
                     && (CW'(tag_q) < base_q + CW'(BUCKET_SLOTS));
  assign e_gt_max  = triple_gt(e_lat, e_key, e_act, max_lat_q, max_key_q, max_act_q);
  assign new_gt_max = triple_gt(rt_q, key_q, act_q, max_lat_q, max_key_q, max_act_q);
  assign scan_done = (ptr_q == CW'(DEPTH)) && !tvld_q;
  assign out_free  = !m_tvalid_q || m_axis_tready_i;
  assign ins_free  = free_vld_q && (n_q < cap_eff);
  assign ins_drop  = !ins_free && (!max_vld_q || new_gt_max);
  assign ins_evict = !ins_free && !ins_drop;
  assign vnext     = nk_vld_q >> 1;
  assign nlast     = (int'(eidx_q) + 1 == int'(cap_eff)) || (int'(eidx_q) == BUCKET_SLOTS - 1)
                     || !vnext[eidx_q];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = max_slot_q;
    mem_wd = {1'b1, key_q, act_q, rt_q};
    if (state_q == S_CLEAR) begin
      mem_we = ptr_q < CW'(DEPTH);
      mem_wa = ptr_q[AW-1:0];
      mem_wd = '0;
    end else if (state_q == S_DECIDE && op_q == ACT_INSERT && !found_q) begin
      mem_we = ins_free || ins_evict;
      if (ins_free) mem_wa = free_q;
    end
  end

  // sorted neighbor list insertion
  logic [BUCKET_SLOTS-1:0] lt;
  always_comb begin
    for (int j = 0; j < BUCKET_SLOTS; j++) begin
      lt[j] = !nk_vld_q[j] || (d_new < (tgt_q ^ nk_key_q[j]))
              || ((d_new == (tgt_q ^ nk_key_q[j])) && (e_act < nk_act_q[j]));
    end
    for (int j = 0; j < BUCKET_SLOTS; j++) begin
      nk_vld_d[j] = nk_vld_q[j];
      nk_key_d[j] = nk_key_q[j];
      nk_act_d[j] = nk_act_q[j];
      nk_lat_d[j] = nk_lat_q[j];
      if (lt[j]) begin
        if (j == 0 || !lt[(j > 0) ? j - 1 : 0]) begin
          nk_vld_d[j] = 1'b1;
          nk_key_d[j] = e_key;
          nk_act_d[j] = e_act;
          nk_lat_d[j] = e_lat;
        end else begin
          nk_vld_d[j] = nk_vld_q[(j > 0) ? j - 1 : 0];
          nk_key_d[j] = nk_key_q[(j > 0) ? j - 1 : 0];
          nk_act_d[j] = nk_act_q[(j > 0) ? j - 1 : 0];
          nk_lat_d[j] = nk_lat_q[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[ptr_q[AW-1:0]];
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      lnk_q      <= '0;
      cap_q      <= CAP_RST;
      ptr_q      <= '0;
      count_q    <= '0;
      tvld_q     <= 1'b0;
      found_q    <= 1'b0;
      free_vld_q <= 1'b0;
      max_vld_q  <= 1'b0;
      n_q        <= '0;
      nk_vld_q   <= '0;
      eidx_q     <= '0;
      m_tvalid_q <= 1'b0;
      m_tlast_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3])
          REG_LOCAL_KEY: lnk_q <= pwdata;
          REG_CAPACITY:  cap_q <= pwdata[CAP_W-1:0];
          default: ;
        endcase
      end
      tvld_q <= (state_q == S_SCAN) && (ptr_q < CW'(DEPTH));
      if (state_q == S_EMIT && out_free) m_tvalid_q <= 1'b1;
      else if (m_axis_tready_i) m_tvalid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          if (ptr_q < CW'(DEPTH)) ptr_q <= ptr_q + 1'b1;
          else begin
            ptr_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            ptr_q      <= '0;
            found_q    <= 1'b0;
            free_vld_q <= 1'b0;
            max_vld_q  <= 1'b0;
            n_q        <= '0;
            nk_vld_q   <= '0;
            eidx_q     <= '0;
            unique case (s_axis_tuser_i)
              ACT_INSERT:  state_q <= self_hit ? S_EMIT : S_LZC;
              ACT_NEAREST,
              ACT_CHECK:   state_q <= S_SCAN;
              default:     state_q <= S_IDLE;
            endcase
          end
        end
        S_LZC: begin
          if (dist_q[KEY_BITS-1]) state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (ptr_q < CW'(DEPTH)) ptr_q <= ptr_q + 1'b1;
          if (hit) found_q <= 1'b1;
          if (in_bkt) begin
            if (!e_vld) free_vld_q <= 1'b1;
            else begin
              n_q <= n_q + 1'b1;
              max_vld_q <= 1'b1;
            end
          end
          if (tvld_q && e_vld && op_q == ACT_NEAREST) nk_vld_q <= nk_vld_d;
          if (scan_done) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (op_q == ACT_INSERT && !found_q && ins_free) count_q <= count_q + 1'b1;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (op_q == ACT_NEAREST && nk_vld_q[0]) begin
              m_tlast_q <= nlast;
              eidx_q    <= eidx_q + 1'b1;
              if (nlast) state_q <= S_IDLE;
            end else begin
              m_tlast_q <= 1'b1;
              state_q   <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    tag_q <= ptr_q[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        op_q       <= s_axis_tuser_i;
        key_q      <= s_axis_tdata_i[KEY_BITS-1:0];
        act_q      <= s_axis_tdata_i[95:64];
        rt_q       <= s_axis_tdata_i[111:96];
        tgt_q      <= s_axis_tdata_i[112 +: KEY_BITS];
        dist_q     <= s_axis_tdata_i[KEY_BITS-1:0] ^ lnk_q[KEY_BITS-1:0];
        bkt_q      <= '0;
        pend_st_q  <= ST_SELF;
        pend_key_q <= '0;
        pend_ref_q <= '0;
        pend_rt_q  <= '0;
        pend_bkt_q <= '0;
      end
      S_LZC: begin
        if (!dist_q[KEY_BITS-1]) begin
          dist_q <= dist_q << 1;
          bkt_q  <= bkt_q + 1'b1;
        end
        base_q <= CW'(int'(bkt_q) * BUCKET_SLOTS);
      end
      S_SCAN: begin
        if (in_bkt) begin
          if (!e_vld) begin
            if (!free_vld_q) free_q <= tag_q;
          end else if (!max_vld_q || e_gt_max) begin
            max_slot_q <= tag_q;
            max_key_q  <= e_key;
            max_act_q  <= e_act;
            max_lat_q  <= e_lat;
          end
        end
        if (tvld_q && e_vld && op_q == ACT_NEAREST) begin
          nk_key_q <= nk_key_d;
          nk_act_q <= nk_act_d;
          nk_lat_q <= nk_lat_d;
        end
      end
      S_DECIDE: begin
        // pending fields still hold the zeros loaded at accept
        case (op_q)
          ACT_INSERT: begin
            if (found_q) pend_st_q <= ST_DUP;
            else begin
              pend_bkt_q <= bkt_q;
              if (ins_free) pend_st_q <= ST_INSERTED;
              else if (ins_drop) begin
                pend_st_q  <= ST_DROPPED;
                pend_key_q <= key_q;
                pend_ref_q <= act_q;
                pend_rt_q  <= rt_q;
              end else begin
                pend_st_q  <= ST_EVICTED;
                pend_key_q <= max_key_q;
                pend_ref_q <= max_act_q;
                pend_rt_q  <= max_lat_q;
              end
            end
          end
          ACT_CHECK: pend_st_q <= found_q ? ST_FOUND : ST_ABSENT;
          default:   pend_st_q <= ST_EMPTY;
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          if (op_q == ACT_NEAREST && nk_vld_q[0]) begin
            m_tdata_q <= {4'b0, SIZE_W'(count_q), BKT_W'(0), nk_lat_q[eidx_q],
                          nk_act_q[eidx_q], KEY_W'(nk_key_q[eidx_q]), ST_NEIGHBOR};
          end else begin
            m_tdata_q <= {4'b0, SIZE_W'(count_q), BKT_W'(pend_bkt_q), pend_rt_q,
                          pend_ref_q, KEY_W'(pend_key_q), pend_st_q};
          end
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = state_q == S_IDLE;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tlast_o  = m_tlast_q;
  assign pready          = 1'b1;
  assign prdata          = paddr[3] ? APB_DW'(cap_q) : lnk_q;

`include "xor_distance_kbucket_table_defines.svh"

  `XDKB_ASSERT_IMPLIES(a_we_legal, mem_we, (state_q == S_CLEAR) || (state_q == S_DECIDE), "slot write outside clear or decide")
  `XDKB_ASSERT_NEXT(a_count_hold, state_q != S_DECIDE, count_q == $past(count_q), "table size moved outside decide")
  `XDKB_ASSERT_IMPLIES(a_list_prefix, state_q != S_CLEAR, ((nk_vld_q + 1'b1) & nk_vld_q) == '0, "neighbor list has a hole")
  `XDKB_ASSERT_IMPLIES(a_ready_quiet, s_axis_tready_o, !tvld_q, "ready while a slot read is in flight")

endmodule

### sim/xor_distance_kbucket_table_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// XOR-distance k-bucket table testbench
// Drives insert, nearest, membership and spare-action beats through several register
// settings, predicts every result beat and checks it field by field.
// ---------------------------------------------------------------------------
module xor_distance_kbucket_table_test;
  import xdkb_pkg::*;

  localparam int SLOTS = BUCKET_SLOTS_DEF;
  localparam int BITS  = KEY_BITS_DEF;
  localparam int DEPTH = SLOTS * BITS;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int SETTLE = 700;
  localparam int WDOG_LIMIT = 6000;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [63:0]      key;
    logic [31:0]      actor;
    logic [15:0]      rtt;
    logic [63:0]      target;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [63:0]       key;
    logic [31:0]       actor;
    logic [15:0]       rtt;
    logic [5:0]        bucket;
    logic [9:0]        size;
    logic              last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic [ACT_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  xor_distance_kbucket_table dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tlast_o(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // table shadow
  logic [63:0] tbl_key [DEPTH];
  logic [31:0] tbl_actor [DEPTH];
  logic [15:0] tbl_rtt [DEPTH];
  logic        tbl_used [DEPTH];
  int          tbl_count;
  logic [63:0] my_key;
  logic [3:0]  cap_reg;

  req_t  pending_q[$];
  beat_t want_q[$];
  logic [63:0] seen_key[$];
  logic [31:0] seen_actor[$];
  int errors = 0, items_sent = 0, beats_seen = 0, evicts = 0, drops = 0, neighbors = 0;
  bit quiet = 1'b0, hold = 1'b0;

  function automatic int eff_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > SLOTS) return SLOTS;
    return cap_reg;
  endfunction

  function automatic int lzc(logic [63:0] d);
    int n;
    n = 0;
    for (int b = BITS - 1; b >= 0; b--) begin
      if (d[b]) break;
      n++;
    end
    return n;
  endfunction

  function automatic bit triple_gt(logic [15:0] l1, logic [63:0] k1, logic [31:0] a1,
                                   logic [15:0] l2, logic [63:0] k2, logic [31:0] a2);
    if (l1 != l2) return l1 > l2;
    if (k1 != k2) return k1 > k2;
    return a1 > a2;
  endfunction

  function automatic int find_pair(logic [63:0] k, logic [31:0] a);
    for (int i = 0; i < DEPTH; i++)
      if (tbl_used[i] && tbl_key[i] == k && tbl_actor[i] == a) return i;
    return -1;
  endfunction

  function automatic void push_beat(logic [STAT_W-1:0] st, logic [63:0] k, logic [31:0] a,
                                    logic [15:0] r, logic [5:0] b, logic l);
    beat_t e;
    e.status = st; e.key = k; e.actor = a; e.rtt = r; e.bucket = b;
    e.size = tbl_count[9:0]; e.last = l;
    want_q.push_back(e);
  endfunction

  function automatic void predict_insert(req_t q);
    int b, free_slot, max_slot, n, s;
    free_slot = -1; max_slot = -1; n = 0;
    if (q.key == my_key) begin
      push_beat(ST_SELF, 0, 0, 0, 0, 1'b1);
      return;
    end
    if (find_pair(q.key, q.actor) >= 0) begin
      push_beat(ST_DUP, 0, 0, 0, 0, 1'b1);
      return;
    end
    b = lzc(my_key ^ q.key);
    for (int j = 0; j < SLOTS; j++) begin
      s = b * SLOTS + j;
      if (!tbl_used[s]) begin
        if (free_slot < 0) free_slot = s;
      end else begin
        n++;
        if (max_slot < 0 || triple_gt(tbl_rtt[s], tbl_key[s], tbl_actor[s],
            tbl_rtt[max_slot], tbl_key[max_slot], tbl_actor[max_slot]))
          max_slot = s;
      end
    end
    if (n < eff_cap() && free_slot >= 0) begin
      tbl_key[free_slot] = q.key; tbl_actor[free_slot] = q.actor;
      tbl_rtt[free_slot] = q.rtt; tbl_used[free_slot] = 1'b1;
      tbl_count++;
      push_beat(ST_INSERTED, 0, 0, 0, b[5:0], 1'b1);
    end else if (max_slot < 0 || triple_gt(q.rtt, q.key, q.actor,
                 tbl_rtt[max_slot], tbl_key[max_slot], tbl_actor[max_slot])) begin
      push_beat(ST_DROPPED, q.key, q.actor, q.rtt, b[5:0], 1'b1);
    end else begin
      push_beat(ST_EVICTED, tbl_key[max_slot], tbl_actor[max_slot], tbl_rtt[max_slot],
                b[5:0], 1'b1);
      tbl_key[max_slot] = q.key; tbl_actor[max_slot] = q.actor; tbl_rtt[max_slot] = q.rtt;
    end
  endfunction

  function automatic void predict_nearest(logic [63:0] tgt);
    int best, cnt;
    bit have_prev;
    logic [63:0] pd, bd, d;
    logic [31:0] pa;
    cnt = 0; have_prev = 0; pd = 0; pa = 0;
    for (int k = 0; k < eff_cap(); k++) begin
      best = -1; bd = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (!tbl_used[i]) continue;
        d = tgt ^ tbl_key[i];
        if (have_prev && (d < pd || (d == pd && tbl_actor[i] <= pa))) continue;
        if (best < 0 || d < bd || (d == bd && tbl_actor[i] < tbl_actor[best])) begin
          best = i; bd = d;
        end
      end
      if (best < 0) break;
      push_beat(ST_NEIGHBOR, tbl_key[best], tbl_actor[best], tbl_rtt[best], 0, 1'b0);
      cnt++; have_prev = 1; pd = bd; pa = tbl_actor[best];
    end
    if (cnt == 0) push_beat(ST_EMPTY, 0, 0, 0, 0, 1'b1);
    else want_q[$].last = 1'b1;
  endfunction

  function automatic void predict_item(req_t q);
    case (q.action)
      ACT_INSERT:  predict_insert(q);
      ACT_NEAREST: predict_nearest(q.target);
      ACT_CHECK:   push_beat(find_pair(q.key, q.actor) >= 0 ? ST_FOUND : ST_ABSENT,
                             0, 0, 0, 0, 1'b1);
      default: ;
    endcase
  endfunction

  // sender
  int send_gap = 0;
  always @(posedge clk_i) begin
    req_t q;
    bit free;
    if (rst_ni) begin
      free = !s_tvalid;
      if (s_tvalid && s_tready) begin
        q = {s_tuser, s_tdata[63:0], s_tdata[95:64], s_tdata[111:96], s_tdata[175:112]};
        predict_item(q);
        items_sent++;
        free = 1'b1;
      end
      if (free) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_q.size() > 0 && !hold) begin
          q = pending_q.pop_front();
          s_tdata <= {q.target, q.rtt, q.actor, q.key};
          s_tuser <= q.action;
          s_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  int recv_gap = 0;
  always @(posedge clk_i) begin
    beat_t got, e;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        beats_seen++;
        got = {m_tdata[3:0], m_tdata[67:4], m_tdata[99:68], m_tdata[115:100],
               m_tdata[121:116], m_tdata[131:122], m_tlast};
        if (got.status == ST_EVICTED) evicts++;
        if (got.status == ST_DROPPED) drops++;
        if (got.status == ST_NEIGHBOR) neighbors++;
        if (want_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %h", got);
        end else begin
          e = want_q.pop_front();
          if (got !== e || m_tdata[135:132] !== 4'd0) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st=%0d key=%h act=%h rtt=%h bkt=%0d size=%0d last=%b\n          got st=%0d key=%h act=%h rtt=%h bkt=%0d size=%0d last=%b pad=%h",
                e.status, e.key, e.actor, e.rtt, e.bucket, e.size, e.last,
                got.status, got.key, got.actor, got.rtt, got.bucket, got.size, got.last,
                m_tdata[135:132]);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 12) == 0) recv_gap = $urandom_range(1, 15);
      end
    end
  end

  // watchdog: stalled cycles while work is outstanding
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (pending_q.size() == 0 && !s_tvalid && want_q.size() == 0)) stuck <= 0;
    else if (stuck >= WDOG_LIMIT) begin
      $display("watchdog expired, %0d beats still expected", want_q.size());
      $display("Some tests failed");
      $finish;
    end else stuck <= stuck + 1;
  end

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_regs(logic [63:0] lk, logic [3:0] cap);
    apb_write(APB_AW'(8 * REG_LOCAL_KEY), lk);
    my_key = lk;
    apb_write(APB_AW'(8 * REG_CAPACITY), {60'd0, cap});
    cap_reg = cap;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !s_tvalid);
    wait (want_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void add(logic [ACT_W-1:0] act, logic [63:0] k, logic [31:0] a,
                              logic [15:0] r, logic [63:0] t);
    req_t q;
    q.action = act; q.key = k; q.actor = a; q.rtt = r; q.target = t;
    pending_q.push_back(q);
    if (act == ACT_INSERT) begin
      seen_key.push_back(k);
      seen_actor.push_back(a);
    end
  endfunction

  function automatic logic [63:0] near_key(int p);
    logic [63:0] m;
    m = (p == 0) ? 64'd0 : ((64'd1 << p) - 1);
    return my_key ^ ((64'd1 << p) | (rand64() & m));
  endfunction

  function automatic void random_item();
    logic [63:0] k, t;
    logic [31:0] a;
    logic [15:0] r;
    int sel, pick, p;
    int ps[4] = '{63, 62, 5, 0};
    sel = $urandom_range(0, 19);
    p = ps[$urandom_range(0, 3)];
    k = rand64(); a = $urandom; r = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: if (seen_key.size() > 0) begin
        pick = $urandom_range(0, seen_key.size() - 1);
        k = seen_key[pick];
        a = ($urandom_range(0, 1) == 0) ? seen_actor[pick] : $urandom_range(0, 3);
      end
      3, 4, 5, 6: k = near_key(p);
      7: k = my_key;
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) r = $urandom_range(0, 3);
    t = ($urandom_range(0, 1) == 0 && seen_key.size() > 0) ?
        seen_key[$urandom_range(0, seen_key.size() - 1)] ^ $urandom_range(0, 255) : rand64();
    if (sel < 11) add(ACT_INSERT, k, a, r, t);
    else if (sel < 15) add(ACT_NEAREST, k, a, r, t);
    else if (sel < 19) add(ACT_CHECK, k, a, r, t);
    else add(ACT_SPARE, k, a, r, t);
  endfunction

  initial begin
    logic [63:0] lk [6];
    logic [3:0]  caps [6];
    for (int i = 0; i < DEPTH; i++) begin
      tbl_key[i] = 0; tbl_actor[i] = 0; tbl_rtt[i] = 0; tbl_used[i] = 0;
    end
    tbl_count = 0; my_key = 0; cap_reg = CAP_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_regs(64'd0, 4'd8);
    // directed
    add(ACT_INSERT, 64'd0, 32'h1, 16'h1, 64'd0);
    add(ACT_NEAREST, 64'd0, 32'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add(ACT_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 64'd0);
    add(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 64'd0);
    add(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 64'd0);
    add(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 16'h0, 64'd0);
    add(ACT_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 64'd0);
    add(ACT_INSERT, 64'd1, 32'd0, 16'hFFFF, 64'd0);
    for (int i = 0; i < 10; i++)
      add(ACT_INSERT, 64'h8000_0000_0000_0000 | i, 32'd7, 16'(10 - i), 64'd0);
    add(ACT_SPARE, rand64(), $urandom, $urandom, rand64());
    add(ACT_NEAREST, 64'd0, 32'd0, 16'd0, 64'h8000_0000_0000_0003);
    add(ACT_NEAREST, 64'd0, 32'd0, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add(ACT_NEAREST, 64'd0, 32'd0, 16'd0, 64'd0);
    drain();

    lk = '{rand64(), rand64(), 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
           rand64(), 64'd0};
    caps = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd2};
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(lk[ph], caps[ph]);
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < 72; n++) begin
        random_item();
        if (ph == 2 && n == 36) begin
          hold = 1'b1;
          wait (!s_tvalid);
          wait (want_q.size() == 0);
          hold = 1'b0;
        end
      end
      drain();
    end

    $display("%0d items sent, %0d beats checked (%0d evictions, %0d drops, %0d neighbors)",
             items_sent, beats_seen, evicts, drops, neighbors);
    $display("six register settings incl. capacity 0, 1, 15 and all-ones local key");
    if (errors == 0 && want_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

### xor_distance_kbucket_table.f
+incdir+rtl
rtl/xdkb_pkg.sv
rtl/xor_distance_kbucket_table.sv
sim/xor_distance_kbucket_table_test.sv
